// ----- design/spot_pkg.sv -----
// Shared types, constants and helpers for the shape pair overlap test core.
// Used by spot_front, spot_queue, spot_back and shape_pair_overlap_test_core.
package spot_pkg;

   localparam int COORD_BITS      = 16;
   // doubled edges grown by a doubled radius need three extra bits
   localparam int EDGE_BITS       = COORD_BITS + 3;
   localparam int DIST_BITS       = COORD_BITS + 2;
   localparam int SQ_BITS         = 2 * DIST_BITS;
   localparam int QUEUE_DEPTH_DEF = 4;

   typedef enum logic [1:0] {
      PAIR_RECT   = 2'd0,
      PAIR_MIXED  = 2'd1,
      PAIR_CIRCLE = 2'd2
   } pair_type;

   typedef struct packed {
      logic                         first_is_circle;
      logic signed [COORD_BITS-1:0] first_center_x;
      logic signed [COORD_BITS-1:0] first_center_y;
      logic [COORD_BITS-1:0]        first_size_x;
      logic [COORD_BITS-1:0]        first_size_y;
      logic                         second_is_circle;
      logic signed [COORD_BITS-1:0] second_center_x;
      logic signed [COORD_BITS-1:0] second_center_y;
      logic [COORD_BITS-1:0]        second_size_x;
      logic [COORD_BITS-1:0]        second_size_y;
   } req_type;

   typedef struct packed {
      logic     overlap;
      pair_type pair_case;
      logic     by_corner;
   } rsp_type;

   // classified item: distances for the square tests plus the flat result
   typedef struct packed {
      pair_type             pair_case;
      logic [DIST_BITS-1:0] dist_x0;
      logic [DIST_BITS-1:0] dist_x1;
      logic [DIST_BITS-1:0] dist_y0;
      logic [DIST_BITS-1:0] dist_y1;
      logic [DIST_BITS-1:0] radius;
      logic                 flat_hit;
   } cmd_type;

   function automatic logic signed [EDGE_BITS-1:0] to_edge(
      input logic signed [COORD_BITS-1:0] c);
      return EDGE_BITS'(c);
   endfunction

   function automatic logic signed [EDGE_BITS-1:0] size_to_edge(
      input logic [COORD_BITS-1:0] s);
      return $signed(EDGE_BITS'(s));
   endfunction

   function automatic logic [DIST_BITS-1:0] abs_diff(
      input logic signed [EDGE_BITS-1:0] a,
      input logic signed [EDGE_BITS-1:0] b);
      logic signed [EDGE_BITS-1:0] d;
      d = a - b;
      if (d < 0) begin
         d = -d;
      end
      return d[DIST_BITS-1:0];
   endfunction

endpackage

// ----- design/spot_front.sv -----
// Front end: orders the pair rectangle first, classifies it and forms edges,
// distances and the span tests. Depends on spot_pkg.
module spot_front (
   input  spot_pkg::req_type req_data,
   output spot_pkg::cmd_type cmd_data
);
   import spot_pkg::*;

   logic                         swap;
   logic                         a_circ;
   logic                         b_circ;
   logic signed [EDGE_BITS-1:0]  ax, ay, bx, by;
   logic signed [EDGE_BITS-1:0]  asx, asy, bsx, bsy;
   logic signed [EDGE_BITS-1:0]  l1, r1, b1, t1;
   logic signed [EDGE_BITS-1:0]  l2, r2, b2, t2;
   logic signed [EDGE_BITS-1:0]  px, py, rad;
   logic                         rect_hit;
   logic                         in_x, in_y, grown;
   pair_type                     kind;

   always_comb begin
      // put a lone circle second
      swap   = req_data.first_is_circle & ~req_data.second_is_circle;
      a_circ = swap ? req_data.second_is_circle : req_data.first_is_circle;
      b_circ = swap ? req_data.first_is_circle  : req_data.second_is_circle;
      ax  = to_edge(swap ? req_data.second_center_x : req_data.first_center_x);
      ay  = to_edge(swap ? req_data.second_center_y : req_data.first_center_y);
      bx  = to_edge(swap ? req_data.first_center_x  : req_data.second_center_x);
      by  = to_edge(swap ? req_data.first_center_y  : req_data.second_center_y);
      asx = size_to_edge(swap ? req_data.second_size_x : req_data.first_size_x);
      asy = size_to_edge(swap ? req_data.second_size_y : req_data.first_size_y);
      bsx = size_to_edge(swap ? req_data.first_size_x  : req_data.second_size_x);
      bsy = size_to_edge(swap ? req_data.first_size_y  : req_data.second_size_y);

      if (a_circ && b_circ) begin
         kind = PAIR_CIRCLE;
      end else if (a_circ || b_circ) begin
         kind = PAIR_MIXED;
      end else begin
         kind = PAIR_RECT;
      end

      l1 = (ax <<< 1) - asx;
      r1 = (ax <<< 1) + asx;
      b1 = (ay <<< 1) - asy;
      t1 = (ay <<< 1) + asy;
      l2 = (bx <<< 1) - bsx;
      r2 = (bx <<< 1) + bsx;
      b2 = (by <<< 1) - bsy;
      t2 = (by <<< 1) + bsy;
      rect_hit = (l1 < r2) && (l2 < r1) && (b1 < t2) && (b2 < t1);

      px    = bx <<< 1;
      py    = by <<< 1;
      rad   = bsx <<< 1;
      in_x  = (px > l1) && (px < r1);
      in_y  = (py > b1) && (py < t1);
      grown = (px > l1 - rad) && (px < r1 + rad) &&
              (py > b1 - rad) && (py < t1 + rad);

      cmd_data.pair_case = kind;
      case (kind)
         PAIR_CIRCLE: begin
            cmd_data.dist_x0  = abs_diff(ax, bx);
            cmd_data.dist_x1  = '0;
            cmd_data.dist_y0  = abs_diff(ay, by);
            cmd_data.dist_y1  = '0;
            cmd_data.radius   = DIST_BITS'(asx + bsx);
            cmd_data.flat_hit = 1'b0;
         end
         PAIR_MIXED: begin
            cmd_data.dist_x0  = abs_diff(px, l1);
            cmd_data.dist_x1  = abs_diff(px, r1);
            cmd_data.dist_y0  = abs_diff(py, b1);
            cmd_data.dist_y1  = abs_diff(py, t1);
            cmd_data.radius   = DIST_BITS'(rad);
            cmd_data.flat_hit = (in_x || in_y) && grown;
         end
         default: begin
            cmd_data.dist_x0  = '0;
            cmd_data.dist_x1  = '0;
            cmd_data.dist_y0  = '0;
            cmd_data.dist_y1  = '0;
            cmd_data.radius   = '0;
            cmd_data.flat_hit = rect_hit;
         end
      endcase
   end

endmodule

// ----- design/spot_queue.sv -----
// Small first-in first-out queue of classified items between front and back.
// Depends on spot_pkg.
module spot_queue #(
   parameter int DEPTH = spot_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spot_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output spot_pkg::cmd_type pop_data,
   output logic              empty
);
   import spot_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         entry_ff [DEPTH];
   logic [IW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !full) |=> !empty)
      else $error("queue lost a written entry");

endmodule

// ----- design/spot_back.sv -----
// Back end: squares the distances and radius, compares, and holds the result
// in the output register. Depends on spot_pkg.
module spot_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  spot_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spot_pkg::rsp_type rsp_data
);
   import spot_pkg::*;

   logic                 advance;
   logic                 sq_valid_ff;
   pair_type             sq_case_ff;
   logic                 sq_flat_ff;
   logic [SQ_BITS-1:0]   sq_x0_ff, sq_x1_ff, sq_y0_ff, sq_y1_ff, sq_rad_ff;
   logic                 near_00, near_01, near_10, near_11;
   logic                 corner_hit;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff, rsp_data_in;

   // move everything forward unless a finished result is held
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign cmd_pop = advance && cmd_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff  <= cmd_valid;
         rsp_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_case_ff  <= cmd_data.pair_case;
         sq_flat_ff  <= cmd_data.flat_hit;
         sq_x0_ff    <= SQ_BITS'(cmd_data.dist_x0) * SQ_BITS'(cmd_data.dist_x0);
         sq_x1_ff    <= SQ_BITS'(cmd_data.dist_x1) * SQ_BITS'(cmd_data.dist_x1);
         sq_y0_ff    <= SQ_BITS'(cmd_data.dist_y0) * SQ_BITS'(cmd_data.dist_y0);
         sq_y1_ff    <= SQ_BITS'(cmd_data.dist_y1) * SQ_BITS'(cmd_data.dist_y1);
         sq_rad_ff   <= SQ_BITS'(cmd_data.radius) * SQ_BITS'(cmd_data.radius);
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      near_00 = ({1'b0, sq_x0_ff} + {1'b0, sq_y0_ff}) < {1'b0, sq_rad_ff};
      near_01 = ({1'b0, sq_x0_ff} + {1'b0, sq_y1_ff}) < {1'b0, sq_rad_ff};
      near_10 = ({1'b0, sq_x1_ff} + {1'b0, sq_y0_ff}) < {1'b0, sq_rad_ff};
      near_11 = ({1'b0, sq_x1_ff} + {1'b0, sq_y1_ff}) < {1'b0, sq_rad_ff};
      corner_hit = near_00 || near_01 || near_10 || near_11;

      rsp_data_in.pair_case = sq_case_ff;
      case (sq_case_ff)
         PAIR_CIRCLE: begin
            rsp_data_in.overlap   = near_00;
            rsp_data_in.by_corner = 1'b0;
         end
         PAIR_MIXED: begin
            rsp_data_in.overlap   = corner_hit || sq_flat_ff;
            rsp_data_in.by_corner = corner_hit;
         end
         default: begin
            rsp_data_in.overlap   = sq_flat_ff;
            rsp_data_in.by_corner = 1'b0;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_corner_implies_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.by_corner) |->
         (rsp_data_ff.overlap && rsp_data_ff.pair_case == PAIR_MIXED))
      else $error("corner flag without a rectangle-circle hit");

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (!rsp_valid_ff || !rsp_stall))
      else $error("queue popped while output held");

endmodule

// ----- design/shape_pair_overlap_test_core.sv -----
// Shape pair overlap test: accepts one pair of shapes (rectangle or circle
// each) per clock while req_stall is low and returns one overlap result per
// pair, in order. A pair is classified in the same cycle it is accepted and
// written to a small queue; a result then passes the queue entry, the
// squaring stage and the output register. Sustained rate is one pair per
// cycle while the output is not stalled, set by the single pipelined squaring
// stage. The queue (DEPTH entries) lets the input side keep transferring
// while the output is stalled; req_stall rises only when it is full.
// Depends on spot_pkg, spot_front, spot_queue and spot_back.
module shape_pair_overlap_test_core #(
   parameter int QUEUE_DEPTH = spot_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spot_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spot_pkg::rsp_type rsp_data
);
   import spot_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_head;
   logic    queue_full;
   logic    queue_empty;
   logic    queue_push;
   logic    queue_pop;

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   spot_front u_front (
      .req_data (req_data),
      .cmd_data (front_cmd)
   );

   spot_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_head),
      .empty     (queue_empty)
   );

   spot_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!queue_empty),
      .cmd_data  (queue_head),
      .cmd_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
